// ===== hdl/sdlk_pkg.sv =====
// Shared types and constants for the SD card lock check sequencer.
// Used by sdlk_cfg, sdlk_seq and sd_spi_init_lock_check; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sdlk_pkg;

    // Configuration register indexes
    localparam logic [2:0] CFG_WAKEUP_BYTES   = 3'd0;
    localparam logic [2:0] CFG_IDLE_ATTEMPTS  = 3'd1;
    localparam logic [2:0] CFG_INIT_ATTEMPTS  = 3'd2;
    localparam logic [2:0] CFG_RESPONSE_POLLS = 3'd3;
    localparam logic [2:0] CFG_BLOCK_LENGTH   = 3'd4;

    localparam int CFG_DATA_W = 16;

    // Register reset values
    localparam logic [7:0]  RST_WAKEUP_BYTES   = 8'd74;
    localparam logic [7:0]  RST_IDLE_ATTEMPTS  = 8'd16;
    localparam logic [15:0] RST_INIT_ATTEMPTS  = 16'd20000;
    localparam logic [3:0]  RST_RESPONSE_POLLS = 4'd10;
    localparam logic [12:0] RST_BLOCK_LENGTH   = 13'd512;

    // Request kinds
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_BYTE  = 1'b1;

    // Verdict codes
    localparam logic [1:0] VERDICT_UNLOCKED = 2'd0;
    localparam logic [1:0] VERDICT_LOCKED   = 2'd1;
    localparam logic [1:0] VERDICT_NO_CARD  = 2'd2;

    // Card kinds
    localparam logic [1:0] CARD_UNKNOWN = 2'd0;
    localparam logic [1:0] CARD_SD_V1   = 2'd1;
    localparam logic [1:0] CARD_SDHC    = 2'd2;

    typedef struct packed {
        logic [7:0]  wakeup_bytes;
        logic [7:0]  idle_attempts;
        logic [15:0] init_attempts;
        logic [3:0]  response_polls;
        logic [12:0] block_length;
    } cfg_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] rx_byte;
    } item_t;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       select_active;
        logic       finished;
        logic [1:0] verdict;
        logic [1:0] card_kind;
    } result_t;

endpackage

`default_nettype wire

// ===== hdl/sdlk_cfg.sv =====
// Configuration register file for the lock check sequencer.
// Depends on sdlk_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sdlk_cfg
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             wr_en,
    input  wire logic [2:0]                       wr_index,
    input  wire logic [sdlk_pkg::CFG_DATA_W-1:0]  wr_data,
    output sdlk_pkg::cfg_t                        cfg
);

    sdlk_pkg::cfg_t cfg_reg;
    sdlk_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                sdlk_pkg::CFG_WAKEUP_BYTES:   cfg_next.wakeup_bytes   = wr_data[7:0];
                sdlk_pkg::CFG_IDLE_ATTEMPTS:  cfg_next.idle_attempts  = wr_data[7:0];
                sdlk_pkg::CFG_INIT_ATTEMPTS:  cfg_next.init_attempts  = wr_data[15:0];
                sdlk_pkg::CFG_RESPONSE_POLLS: cfg_next.response_polls = wr_data[3:0];
                sdlk_pkg::CFG_BLOCK_LENGTH:   cfg_next.block_length   = wr_data[12:0];
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.wakeup_bytes   <= sdlk_pkg::RST_WAKEUP_BYTES;
            cfg_reg.idle_attempts  <= sdlk_pkg::RST_IDLE_ATTEMPTS;
            cfg_reg.init_attempts  <= sdlk_pkg::RST_INIT_ATTEMPTS;
            cfg_reg.response_polls <= sdlk_pkg::RST_RESPONSE_POLLS;
            cfg_reg.block_length   <= sdlk_pkg::RST_BLOCK_LENGTH;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== hdl/sdlk_seq.sv =====
// Sequencer state and next-byte logic: one step per request, a start command or a completed byte exchange.
// Depends on sdlk_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sdlk_seq
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step_en,
    input  wire sdlk_pkg::item_t   item,
    input  wire sdlk_pkg::cfg_t    cfg,
    output sdlk_pkg::result_t      result
);

    localparam logic [3:0] PH_DONE_CARD   = 4'd0;
    localparam logic [3:0] PH_DONE_NOCARD = 4'd1;
    localparam logic [3:0] PH_WAKE        = 4'd2;
    localparam logic [3:0] PH_IDLE_CMD    = 4'd3;
    localparam logic [3:0] PH_BLK1        = 4'd4;
    localparam logic [3:0] PH_IFCOND      = 4'd5;
    localparam logic [3:0] PH_BURN_HC     = 4'd6;
    localparam logic [3:0] PH_ACMD        = 4'd7;
    localparam logic [3:0] PH_OCR         = 4'd8;
    localparam logic [3:0] PH_BURN_SD     = 4'd9;
    localparam logic [3:0] PH_CMD1        = 4'd10;
    localparam logic [3:0] PH_BLK2        = 4'd11;
    localparam logic [3:0] PH_TAIL        = 4'd12;
    localparam logic [3:0] PH_STATUS      = 4'd13;
    localparam logic [3:0] PH_STAT2       = 4'd14;
    localparam logic [3:0] PH_STAT3       = 4'd15;

    // Command codes; bit 7 marks an application command needing the CMD55 prefix
    localparam logic [7:0] CMD_GO_IDLE   = 8'h40;
    localparam logic [7:0] CMD_SEND_OP   = 8'h41;
    localparam logic [7:0] CMD_IF_COND   = 8'h48;
    localparam logic [7:0] CMD_STATUS    = 8'h4D;
    localparam logic [7:0] CMD_BLOCK_LEN = 8'h50;
    localparam logic [7:0] CMD_APP_OP    = 8'h69;
    localparam logic [7:0] CMD_APP_CMD   = 8'h77;
    localparam logic [7:0] CMD_READ_OCR  = 8'h7A;
    localparam logic [7:0] CMD_ACMD41    = 8'hE9;

    localparam logic [7:0] CRC_GO_IDLE = 8'h95;
    localparam logic [7:0] CRC_IF_COND = 8'h87;
    localparam logic [7:0] FILL        = 8'hFF;

    localparam logic [31:0] ARG_IF_COND = 32'h0000_01AA;
    localparam logic [31:0] ARG_HCS     = 32'h4000_0000;

    logic [3:0]  phase_reg,   phase_next;
    logic [3:0]  frame_reg,   frame_next;
    logic [3:0]  poll_reg,    poll_next;
    logic [15:0] retry_reg,   retry_next;
    logic [7:0]  code_reg,    code_next;
    logic [31:0] arg_reg,     arg_next;
    logic        prefix_reg,  prefix_next;
    logic [1:0]  kind_reg,    kind_next;
    logic        locked_reg,  locked_next;
    logic [7:0]  last_reg,    last_next;
    logic        sel_reg,     sel_next;

    logic [7:0]  tx;
    logic [7:0]  act_code;
    logic [31:0] act_arg;
    logic        trailing;
    logic [3:0]  polls;
    logic [15:0] retry_inc;
    logic [3:0]  frame_inc;
    logic [7:0]  resp;
    logic        fin;
    logic        cmd_done;
    logic        do_start;
    logic [7:0]  st_code;
    logic [31:0] st_arg;
    logic        done;

    function automatic logic [7:0] frame_byte(input logic [3:0] idx, input logic [7:0] code,
                                              input logic [31:0] arg);
        logic [7:0] b;
        case (idx)
            4'd2:    b = code;
            4'd3:    b = arg[31:24];
            4'd4:    b = arg[23:16];
            4'd5:    b = arg[15:8];
            4'd6:    b = arg[7:0];
            default:
            begin
                if (code == CMD_GO_IDLE)
                    b = CRC_GO_IDLE;
                else if (code == CMD_IF_COND)
                    b = CRC_IF_COND;
                else
                    b = FILL;
            end
        endcase
        return b;
    endfunction

    assign act_code  = prefix_reg ? CMD_APP_CMD : {2'b01, code_reg[5:0]};
    assign act_arg   = prefix_reg ? 32'd0 : arg_reg;
    assign trailing  = (act_code == CMD_GO_IDLE) || (act_code == CMD_SEND_OP) ||
                       (act_code == CMD_BLOCK_LEN) || (act_code == CMD_APP_OP) ||
                       (act_code == CMD_APP_CMD);
    assign polls     = (cfg.response_polls == 4'd0) ? 4'd1 : cfg.response_polls;
    assign retry_inc = retry_reg + 16'd1;
    assign frame_inc = frame_reg + 4'd1;

    always_comb
    begin
        phase_next  = phase_reg;
        frame_next  = frame_reg;
        poll_next   = poll_reg;
        retry_next  = retry_reg;
        code_next   = code_reg;
        arg_next    = arg_reg;
        prefix_next = prefix_reg;
        kind_next   = kind_reg;
        locked_next = locked_reg;
        last_next   = last_reg;
        sel_next    = sel_reg;
        tx          = FILL;
        resp        = last_reg;
        fin         = 1'b0;
        cmd_done    = 1'b0;
        do_start    = 1'b0;
        st_code     = CMD_GO_IDLE;
        st_arg      = 32'd0;

        if (item.kind == sdlk_pkg::KIND_START)
        begin
            kind_next   = sdlk_pkg::CARD_UNKNOWN;
            locked_next = 1'b0;
            last_next   = FILL;
            prefix_next = 1'b0;
            frame_next  = 4'd0;
            poll_next   = 4'd0;
            phase_next  = PH_WAKE;
            retry_next  = 16'd1;
            sel_next    = 1'b0;
        end
        else
        begin
            case (phase_reg)
                PH_WAKE:
                begin
                    if (retry_reg >= {8'd0, cfg.wakeup_bytes})
                    begin
                        phase_next = PH_IDLE_CMD;
                        retry_next = 16'd0;
                        do_start   = 1'b1;
                    end
                    else
                    begin
                        retry_next = retry_inc;
                        sel_next   = 1'b0;
                    end
                end
                PH_IDLE_CMD, PH_BLK1, PH_IFCOND, PH_ACMD,
                PH_OCR, PH_CMD1, PH_BLK2, PH_STATUS:
                begin
                    if (frame_reg <= 4'd6)
                    begin
                        frame_next = frame_inc;
                        tx         = (frame_reg == 4'd0) ? FILL
                                                         : frame_byte(frame_inc, act_code, act_arg);
                        sel_next   = 1'b1;
                    end
                    else if (frame_reg == 4'd7)
                    begin
                        frame_next = 4'd8;
                        poll_next  = 4'd1;
                        sel_next   = 1'b1;
                    end
                    else
                    begin
                        fin = 1'b1;
                        if (frame_reg == 4'd8)
                        begin
                            last_next = item.rx_byte;
                            resp      = item.rx_byte;
                            if (item.rx_byte[7] && (poll_reg < polls))
                            begin
                                poll_next = poll_reg + 4'd1;
                                sel_next  = 1'b1;
                                fin       = 1'b0;
                            end
                            else if (trailing)
                            begin
                                frame_next = 4'd9;
                                sel_next   = 1'b0;
                                fin        = 1'b0;
                            end
                        end
                        if (fin)
                        begin
                            // prefix accepted: go on to the application command itself
                            if (prefix_reg && (resp <= 8'd1))
                            begin
                                prefix_next = 1'b0;
                                frame_next  = 4'd0;
                                poll_next   = 4'd0;
                                sel_next    = 1'b0;
                            end
                            else
                            begin
                                cmd_done = 1'b1;
                            end
                        end
                    end
                end
                PH_BURN_HC, PH_BURN_SD:
                begin
                    if (frame_reg < 4'd4)
                    begin
                        frame_next = frame_inc;
                    end
                    else if (phase_reg == PH_BURN_HC)
                    begin
                        phase_next = PH_ACMD;
                        retry_next = 16'd0;
                        do_start   = 1'b1;
                        st_code    = CMD_ACMD41;
                        st_arg     = ARG_HCS;
                    end
                    else
                    begin
                        phase_next = PH_CMD1;
                        retry_next = 16'd0;
                        do_start   = 1'b1;
                        st_code    = CMD_SEND_OP;
                    end
                end
                PH_TAIL:
                begin
                    phase_next = PH_STATUS;
                    do_start   = 1'b1;
                    st_code    = CMD_STATUS;
                end
                PH_STAT2:
                begin
                    locked_next = item.rx_byte[0];
                    phase_next  = PH_STAT3;
                end
                PH_STAT3:
                begin
                    phase_next = PH_DONE_CARD;
                    sel_next   = 1'b0;
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end

        if (cmd_done)
        begin
            case (phase_reg)
                PH_IDLE_CMD:
                begin
                    if (resp == 8'd1)
                    begin
                        phase_next = PH_BLK1;
                        do_start   = 1'b1;
                        st_code    = CMD_BLOCK_LEN;
                        st_arg     = {19'd0, cfg.block_length};
                    end
                    else
                    begin
                        retry_next = retry_inc;
                        if (retry_inc >= {8'd0, cfg.idle_attempts})
                        begin
                            phase_next = PH_DONE_NOCARD;
                            sel_next   = 1'b0;
                        end
                        else
                        begin
                            do_start = 1'b1;
                        end
                    end
                end
                PH_BLK1:
                begin
                    phase_next = PH_IFCOND;
                    do_start   = 1'b1;
                    st_code    = CMD_IF_COND;
                    st_arg     = ARG_IF_COND;
                end
                PH_IFCOND:
                begin
                    if (resp == 8'd1)
                    begin
                        phase_next = PH_BURN_HC;
                        frame_next = 4'd1;
                    end
                    else
                    begin
                        phase_next = PH_OCR;
                        do_start   = 1'b1;
                        st_code    = CMD_READ_OCR;
                    end
                end
                PH_ACMD:
                begin
                    retry_next = retry_inc;
                    if ((resp == 8'd0) || (retry_inc >= cfg.init_attempts))
                    begin
                        kind_next  = sdlk_pkg::CARD_SDHC;
                        phase_next = PH_TAIL;
                    end
                    else
                    begin
                        do_start = 1'b1;
                        st_code  = CMD_ACMD41;
                        st_arg   = ARG_HCS;
                    end
                end
                PH_OCR:
                begin
                    if (resp == 8'd1)
                    begin
                        phase_next = PH_BURN_SD;
                        frame_next = 4'd1;
                    end
                    else
                    begin
                        phase_next = PH_CMD1;
                        retry_next = 16'd0;
                        do_start   = 1'b1;
                        st_code    = CMD_SEND_OP;
                    end
                end
                PH_CMD1:
                begin
                    retry_next = retry_inc;
                    do_start   = 1'b1;
                    if ((resp == 8'd0) || (retry_inc >= cfg.init_attempts))
                    begin
                        phase_next = PH_BLK2;
                        st_code    = CMD_BLOCK_LEN;
                        st_arg     = {19'd0, cfg.block_length};
                    end
                    else
                    begin
                        st_code = CMD_SEND_OP;
                    end
                end
                PH_BLK2:
                begin
                    kind_next  = sdlk_pkg::CARD_SD_V1;
                    phase_next = PH_TAIL;
                end
                default:
                begin
                    phase_next = PH_STAT2;
                end
            endcase
        end

        if (do_start)
        begin
            code_next   = st_code;
            arg_next    = st_arg;
            prefix_next = st_code[7];
            frame_next  = 4'd0;
            poll_next   = 4'd0;
            sel_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_DONE_CARD;
            frame_reg  <= 4'd0;
            poll_reg   <= 4'd0;
            retry_reg  <= 16'd0;
            code_reg   <= 8'd0;
            arg_reg    <= 32'd0;
            prefix_reg <= 1'b0;
            kind_reg   <= sdlk_pkg::CARD_UNKNOWN;
            locked_reg <= 1'b0;
            last_reg   <= FILL;
            sel_reg    <= 1'b0;
        end
        else if (step_en)
        begin
            phase_reg  <= phase_next;
            frame_reg  <= frame_next;
            poll_reg   <= poll_next;
            retry_reg  <= retry_next;
            code_reg   <= code_next;
            arg_reg    <= arg_next;
            prefix_reg <= prefix_next;
            kind_reg   <= kind_next;
            locked_reg <= locked_next;
            last_reg   <= last_next;
            sel_reg    <= sel_next;
        end
    end

    assign done = (phase_next == PH_DONE_CARD) || (phase_next == PH_DONE_NOCARD);

    always_comb
    begin
        result.card_kind = kind_next;
        if (done)
        begin
            result.tx_byte       = FILL;
            result.select_active = 1'b0;
            result.finished      = 1'b1;
            if (phase_next == PH_DONE_NOCARD)
                result.verdict = sdlk_pkg::VERDICT_NO_CARD;
            else
                result.verdict = locked_next ? sdlk_pkg::VERDICT_LOCKED
                                             : sdlk_pkg::VERDICT_UNLOCKED;
        end
        else
        begin
            result.tx_byte       = tx;
            result.select_active = sel_next;
            result.finished      = 1'b0;
            result.verdict       = sdlk_pkg::VERDICT_UNLOCKED;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/sd_spi_init_lock_check.sv =====
// SD card lock check sequencer, SPI mode: top level with request and result registers.
// Depends on sdlk_pkg, sdlk_cfg and sdlk_seq.
`timescale 1ns / 1ps
`default_nettype none

// Each request is a start command or one completed SPI byte exchange; each gives exactly one
// result holding the next byte to send, the chip-select level and, once the sequence ends, the
// verdict. A request is taken while the request register is empty or being emptied; it waits
// there, the sequencer step runs between that register and the result register, and the result
// is registered once the result slot is free. The sustained rate is one request per cycle
// whenever the result side keeps taking results. Configuration writes take effect on the next
// cycle and are always accepted; write them only while no request is in flight.
module sd_spi_init_lock_check
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            item_valid,
    output      logic                            item_ready,
    input  wire sdlk_pkg::item_t                 item,
    output      logic                            result_valid,
    input  wire logic                            result_ready,
    output sdlk_pkg::result_t                    result,
    input  wire logic                            cfg_valid,
    output      logic                            cfg_ready,
    input  wire logic [2:0]                      cfg_index,
    input  wire logic [sdlk_pkg::CFG_DATA_W-1:0] cfg_data
);

    sdlk_pkg::cfg_t    cfg;
    sdlk_pkg::item_t   item_reg;
    sdlk_pkg::result_t step_result;
    sdlk_pkg::result_t result_reg;
    logic              item_vld_reg, item_vld_next;
    logic              res_vld_reg,  res_vld_next;
    logic              advance;
    logic              step_en;
    logic              item_take;

    assign cfg_ready = 1'b1;

    sdlk_cfg u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid & cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // result slot free or being emptied this cycle
    assign advance    = !res_vld_reg || result_ready;
    assign step_en    = advance && item_vld_reg;
    assign item_ready = !item_vld_reg || advance;
    assign item_take  = item_valid && item_ready;

    sdlk_seq u_seq
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (step_en),
        .item    (item_reg),
        .cfg     (cfg),
        .result  (step_result)
    );

    always_comb
    begin
        item_vld_next = item_vld_reg;
        if (item_take)
            item_vld_next = 1'b1;
        else if (advance)
            item_vld_next = 1'b0;

        res_vld_next = res_vld_reg;
        if (advance)
            res_vld_next = item_vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_vld_reg <= 1'b0;
            res_vld_reg  <= 1'b0;
        end
        else
        begin
            item_vld_reg <= item_vld_next;
            res_vld_reg  <= res_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
            item_reg <= item;
        if (step_en)
            result_reg <= step_result;
    end

    assign result_valid = res_vld_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

// ===== tb/sv/sd_spi_init_lock_check_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for sd_spi_init_lock_check: an emulated card answers each request and a
// bit-exact sequencer predictor checks every result. Depends on sdlk_pkg and the RTL top only.

module sd_spi_init_lock_check_test;
    import sdlk_pkg::*;

    typedef enum logic [4:0] {
        PH_DONE_CARD   = 5'd0,
        PH_DONE_NOCARD = 5'd1,
        PH_WAKE        = 5'd2,
        PH_IDLE_CMD    = 5'd3,
        PH_BLK1        = 5'd4,
        PH_IFCOND      = 5'd5,
        PH_BURN_HC     = 5'd6,
        PH_ACMD        = 5'd7,
        PH_OCR         = 5'd8,
        PH_BURN_SD     = 5'd9,
        PH_CMD1        = 5'd10,
        PH_BLK2        = 5'd11,
        PH_TAIL        = 5'd12,
        PH_STATUS      = 5'd13,
        PH_STAT2       = 5'd14,
        PH_STAT3       = 5'd15
    } seq_phase_e;

    // Command bytes as framed on the wire; ACMD41 carries bit 7 to ask for a CMD55 prefix
    localparam logic [7:0] CMD_GO_IDLE    = 8'h40;
    localparam logic [7:0] CMD_SEND_OP    = 8'h41;
    localparam logic [7:0] CMD_IF_COND    = 8'h48;
    localparam logic [7:0] CMD_STATUS     = 8'h4D;
    localparam logic [7:0] CMD_BLOCK_LEN  = 8'h50;
    localparam logic [7:0] CMD_READ_OCR   = 8'h7A;
    localparam logic [7:0] CMD_APP_CMD    = 8'h77;
    localparam logic [7:0] ACMD_OP_COND   = 8'hE9;
    localparam logic [7:0] ACMD_OP_FRAMED = 8'h69;
    localparam logic [7:0] CRC_GO_IDLE    = 8'h95;
    localparam logic [7:0] CRC_IF_COND    = 8'h87;
    localparam logic [7:0] FILL           = 8'hFF;
    localparam logic [31:0] IF_COND_ARG   = 32'h0000_01AA;
    localparam logic [31:0] HCS_ARG       = 32'h4000_0000;

    // R1 replies used by the emulated card
    localparam logic [7:0] R1_READY   = 8'h00;
    localparam logic [7:0] R1_IDLE    = 8'h01;
    localparam logic [7:0] R1_ILLEGAL = 8'h05;

    typedef struct packed {
        seq_phase_e  phase;
        logic [3:0]  frame_index;
        logic [3:0]  poll_count;
        logic [15:0] retry_count;
        logic [7:0]  command_code;
        logic [31:0] command_argument;
        logic        prefix_pending;
        logic [1:0]  detected_kind;
        logic [7:0]  status_second;
        logic [7:0]  last_response;
        logic        select_level;
        logic [7:0]  out_tx;
        cfg_t        cfg;
    } seq_state_t;

    typedef enum {PROBE_ABSENT, PROBE_HC, PROBE_V1, PROBE_MMC} probe_card_e;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  item_valid = 1'b0;
    logic                  item_ready;
    item_t                 item = '0;
    logic                  result_valid;
    logic                  result_ready = 1'b0;
    result_t               result;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [2:0]            cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    seq_state_t  check_state;
    seq_state_t  plan_state;
    probe_card_e probe;
    item_t       pending_items[$];
    result_t     expected_results[$];
    result_t     predicted;
    result_t     observed;
    logic        item_taken = 1'b0;
    logic        cfg_taken = 1'b0;
    logic        last_finished = 1'b1;
    int          send_idle_pct = 0;
    int          result_stall_pct = 0;
    int          error_count = 0;
    int          results_checked = 0;
    int          verdict_seen [3] = '{0, 0, 0};

    sd_spi_init_lock_check u_top
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #2 clk = ~clk;

    function automatic seq_state_t reset_state();
        seq_state_t s;
        s = '0;
        s.phase = PH_DONE_CARD;
        s.last_response = FILL;
        s.out_tx = FILL;
        s.cfg.wakeup_bytes = RST_WAKEUP_BYTES;
        s.cfg.idle_attempts = RST_IDLE_ATTEMPTS;
        s.cfg.init_attempts = RST_INIT_ATTEMPTS;
        s.cfg.response_polls = RST_RESPONSE_POLLS;
        s.cfg.block_length = RST_BLOCK_LENGTH;
        return s;
    endfunction

    function automatic void apply_reg(inout cfg_t c, input logic [2:0] idx,
                                      input logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_WAKEUP_BYTES:   c.wakeup_bytes = val[7:0];
            CFG_IDLE_ATTEMPTS:  c.idle_attempts = val[7:0];
            CFG_INIT_ATTEMPTS:  c.init_attempts = val[15:0];
            CFG_RESPONSE_POLLS: c.response_polls = val[3:0];
            CFG_BLOCK_LENGTH:   c.block_length = val[12:0];
            default: ;
        endcase
    endfunction

    function automatic void start_cmd(inout seq_state_t s, input logic [7:0] code,
                                      input logic [31:0] arg);
        s.command_code = code;
        s.command_argument = arg;
        s.prefix_pending = code[7];
        s.frame_index = 4'd0;
        s.poll_count = 4'd0;
        s.out_tx = FILL;
        s.select_level = 1'b0;
    endfunction

    // One request through the sequencer: updates the state and gives the result it produces
    function automatic void seq_step(inout seq_state_t s, input item_t it, output result_t r);
        logic [7:0]  code;
        logic [31:0] arg;
        logic [3:0]  polls;
        logic [7:0]  resp;
        logic        cmd_done;

        cmd_done = 1'b0;
        resp = s.last_response;
        if (it.kind == KIND_START)
        begin
            s.detected_kind = CARD_UNKNOWN;
            s.status_second = 8'h00;
            s.last_response = FILL;
            s.prefix_pending = 1'b0;
            s.frame_index = 4'd0;
            s.poll_count = 4'd0;
            s.phase = PH_WAKE;
            s.retry_count = 16'd1;
            s.out_tx = FILL;
            s.select_level = 1'b0;
        end
        else
        begin
            case (s.phase)
                PH_WAKE:
                begin
                    if (s.retry_count >= s.cfg.wakeup_bytes)
                    begin
                        s.phase = PH_IDLE_CMD;
                        s.retry_count = 16'd0;
                        start_cmd(s, CMD_GO_IDLE, 32'd0);
                    end
                    else
                    begin
                        s.retry_count = s.retry_count + 16'd1;
                        s.out_tx = FILL;
                        s.select_level = 1'b0;
                    end
                end
                PH_IDLE_CMD, PH_BLK1, PH_IFCOND, PH_ACMD, PH_OCR, PH_CMD1, PH_BLK2, PH_STATUS:
                begin
                    code = s.prefix_pending ? CMD_APP_CMD : {2'b01, s.command_code[5:0]};
                    arg = s.prefix_pending ? 32'd0 : s.command_argument;
                    polls = (s.cfg.response_polls == 4'd0) ? 4'd1 : s.cfg.response_polls;
                    if (s.frame_index <= 4'd6)
                    begin
                        s.frame_index = s.frame_index + 4'd1;
                        s.select_level = 1'b1;
                        case (s.frame_index)
                            4'd1: s.out_tx = FILL;
                            4'd2: s.out_tx = code;
                            4'd3: s.out_tx = arg[31:24];
                            4'd4: s.out_tx = arg[23:16];
                            4'd5: s.out_tx = arg[15:8];
                            4'd6: s.out_tx = arg[7:0];
                            default: s.out_tx = (code == CMD_GO_IDLE) ? CRC_GO_IDLE :
                                                (code == CMD_IF_COND) ? CRC_IF_COND : FILL;
                        endcase
                    end
                    else if (s.frame_index == 4'd7)
                    begin
                        s.frame_index = 4'd8;
                        s.poll_count = 4'd1;
                        s.out_tx = FILL;
                        s.select_level = 1'b1;
                    end
                    else
                    begin
                        if (s.frame_index == 4'd8)
                        begin
                            s.last_response = it.rx_byte;
                            if (it.rx_byte[7] && s.poll_count < polls)
                            begin
                                s.poll_count = s.poll_count + 4'd1;
                                s.out_tx = FILL;
                                s.select_level = 1'b1;
                            end
                            else if (code == CMD_GO_IDLE || code == CMD_SEND_OP ||
                                     code == CMD_BLOCK_LEN || code == ACMD_OP_FRAMED ||
                                     code == CMD_APP_CMD)
                            begin
                                s.frame_index = 4'd9;
                                s.out_tx = FILL;
                                s.select_level = 1'b0;
                            end
                            else
                                cmd_done = 1'b1;
                        end
                        else
                            cmd_done = 1'b1;
                        resp = s.last_response;
                        // CMD55 accepted: go on with the ACMD41 frame itself
                        if (cmd_done && s.prefix_pending && resp <= 8'd1)
                        begin
                            cmd_done = 1'b0;
                            s.prefix_pending = 1'b0;
                            s.frame_index = 4'd0;
                            s.poll_count = 4'd0;
                            s.out_tx = FILL;
                            s.select_level = 1'b0;
                        end
                    end
                    if (cmd_done)
                    begin
                        case (s.phase)
                            PH_IDLE_CMD:
                            begin
                                if (resp == R1_IDLE)
                                begin
                                    s.phase = PH_BLK1;
                                    start_cmd(s, CMD_BLOCK_LEN, {19'd0, s.cfg.block_length});
                                end
                                else
                                begin
                                    s.retry_count = s.retry_count + 16'd1;
                                    if (s.retry_count >= s.cfg.idle_attempts)
                                    begin
                                        s.phase = PH_DONE_NOCARD;
                                        s.out_tx = FILL;
                                        s.select_level = 1'b0;
                                    end
                                    else
                                        start_cmd(s, CMD_GO_IDLE, 32'd0);
                                end
                            end
                            PH_BLK1:
                            begin
                                s.phase = PH_IFCOND;
                                start_cmd(s, CMD_IF_COND, IF_COND_ARG);
                            end
                            PH_IFCOND:
                            begin
                                if (resp == R1_IDLE)
                                begin
                                    s.phase = PH_BURN_HC;
                                    s.frame_index = 4'd1;
                                    s.out_tx = FILL;
                                end
                                else
                                begin
                                    s.phase = PH_OCR;
                                    start_cmd(s, CMD_READ_OCR, 32'd0);
                                end
                            end
                            PH_ACMD:
                            begin
                                s.retry_count = s.retry_count + 16'd1;
                                if (resp == R1_READY || s.retry_count >= s.cfg.init_attempts)
                                begin
                                    s.detected_kind = CARD_SDHC;
                                    s.phase = PH_TAIL;
                                    s.out_tx = FILL;
                                end
                                else
                                    start_cmd(s, ACMD_OP_COND, HCS_ARG);
                            end
                            PH_OCR:
                            begin
                                if (resp == R1_IDLE)
                                begin
                                    s.phase = PH_BURN_SD;
                                    s.frame_index = 4'd1;
                                    s.out_tx = FILL;
                                end
                                else
                                begin
                                    s.phase = PH_CMD1;
                                    s.retry_count = 16'd0;
                                    start_cmd(s, CMD_SEND_OP, 32'd0);
                                end
                            end
                            PH_CMD1:
                            begin
                                s.retry_count = s.retry_count + 16'd1;
                                if (resp == R1_READY || s.retry_count >= s.cfg.init_attempts)
                                begin
                                    s.phase = PH_BLK2;
                                    start_cmd(s, CMD_BLOCK_LEN, {19'd0, s.cfg.block_length});
                                end
                                else
                                    start_cmd(s, CMD_SEND_OP, 32'd0);
                            end
                            PH_BLK2:
                            begin
                                s.detected_kind = CARD_SD_V1;
                                s.phase = PH_TAIL;
                                s.out_tx = FILL;
                            end
                            default:
                            begin
                                s.phase = PH_STAT2;
                                s.out_tx = FILL;
                            end
                        endcase
                    end
                end
                PH_BURN_HC, PH_BURN_SD:
                begin
                    if (s.frame_index < 4'd4)
                    begin
                        s.frame_index = s.frame_index + 4'd1;
                        s.out_tx = FILL;
                    end
                    else if (s.phase == PH_BURN_HC)
                    begin
                        s.phase = PH_ACMD;
                        s.retry_count = 16'd0;
                        start_cmd(s, ACMD_OP_COND, HCS_ARG);
                    end
                    else
                    begin
                        s.phase = PH_CMD1;
                        s.retry_count = 16'd0;
                        start_cmd(s, CMD_SEND_OP, 32'd0);
                    end
                end
                PH_TAIL:
                begin
                    s.phase = PH_STATUS;
                    start_cmd(s, CMD_STATUS, 32'd0);
                end
                PH_STAT2:
                begin
                    s.status_second = it.rx_byte;
                    s.phase = PH_STAT3;
                    s.out_tx = FILL;
                end
                PH_STAT3:
                begin
                    s.phase = PH_DONE_CARD;
                    s.out_tx = FILL;
                    s.select_level = 1'b0;
                end
                default: ;
            endcase
        end

        if (s.phase == PH_DONE_CARD || s.phase == PH_DONE_NOCARD)
        begin
            r.tx_byte = FILL;
            r.select_active = 1'b0;
            r.finished = 1'b1;
            if (s.phase == PH_DONE_NOCARD)
                r.verdict = VERDICT_NO_CARD;
            else
                r.verdict = s.status_second[0] ? VERDICT_LOCKED : VERDICT_UNLOCKED;
        end
        else
        begin
            r.tx_byte = s.out_tx;
            r.select_active = s.select_level;
            r.finished = 1'b0;
            r.verdict = VERDICT_UNLOCKED;
        end
        r.card_kind = s.detected_kind;
    endfunction

    // Queues a request and advances the planning copy so the card can answer in context
    function automatic void push_item(input logic kind, input logic [7:0] rx);
        item_t   it;
        result_t unused;
        it.kind = kind;
        it.rx_byte = rx;
        seq_step(plan_state, it, unused);
        pending_items.push_back(it);
    endfunction

    task automatic wait_drained();
        while (pending_items.size() != 0 || item_valid || expected_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do
            @(negedge clk);
        while (!cfg_taken);
        apply_reg(plan_state.cfg, idx, val);
    endtask

    task automatic run_phase(input logic [15:0] wake, idle, init, polls, blk,
                             input int send_pct, stall_pct, n, input bit allow_absent);
        int         made;
        int         roll;
        logic [7:0] rx;

        write_reg(CFG_WAKEUP_BYTES, wake);
        write_reg(CFG_IDLE_ATTEMPTS, idle);
        write_reg(CFG_INIT_ATTEMPTS, init);
        write_reg(CFG_RESPONSE_POLLS, polls);
        write_reg(CFG_BLOCK_LENGTH, blk);
        cfg_valid <= 1'b0;
        send_idle_pct = send_pct;
        result_stall_pct = stall_pct;

        made = 0;
        while (made < n)
        begin
            if ((plan_state.phase == PH_DONE_CARD || plan_state.phase == PH_DONE_NOCARD) &&
                $urandom_range(9) == 0)
                push_item(KIND_BYTE, 8'($urandom_range(255)));
            else if (plan_state.phase == PH_DONE_CARD || plan_state.phase == PH_DONE_NOCARD ||
                     $urandom_range(299) == 0)
            begin
                roll = $urandom_range(99);
                if (allow_absent && roll < 12)
                    probe = PROBE_ABSENT;
                else if (roll < 50)
                    probe = PROBE_HC;
                else if (roll < 75)
                    probe = PROBE_V1;
                else
                    probe = PROBE_MMC;
                push_item(KIND_START, 8'($urandom_range(255)));
                made++;
            end
            else
            begin
                roll = $urandom_range(99);
                if (roll < 5 || plan_state.phase == PH_STAT2)
                    rx = 8'($urandom_range(255));
                else if (plan_state.frame_index != 4'd8)
                    rx = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : FILL;
                else if (roll < 40)
                    rx = ($urandom_range(1) == 0) ? FILL : (8'h80 | 8'($urandom_range(127)));
                else
                begin
                    // reply to a poll, shaped by the kind of card being emulated
                    case (plan_state.phase)
                        PH_IDLE_CMD:
                            if (probe == PROBE_ABSENT)
                                rx = ($urandom_range(1) == 0) ? R1_ILLEGAL : R1_READY;
                            else
                                rx = (roll < 85) ? R1_IDLE : R1_READY;
                        PH_IFCOND:
                            rx = (probe == PROBE_HC) ? R1_IDLE : R1_ILLEGAL;
                        PH_ACMD:
                            if (plan_state.prefix_pending)
                                rx = (roll < 48) ? R1_ILLEGAL : (roll < 56) ? R1_READY : R1_IDLE;
                            else
                                rx = (roll < 65) ? R1_READY : R1_IDLE;
                        PH_OCR:
                            rx = (probe == PROBE_V1) ? R1_IDLE : R1_ILLEGAL;
                        PH_CMD1:
                            rx = (roll < 65) ? R1_READY : R1_IDLE;
                        default:
                            rx = 8'($urandom_range(127));
                    endcase
                end
                push_item(KIND_BYTE, rx);
                made++;
            end
        end
        wait_drained();
    endtask

    // Driver: requests change on the falling edge, held until taken
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!item_valid || item_taken)
            begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    item <= pending_items.pop_front();
                    item_valid <= 1'b1;
                end
                else
                    item_valid <= 1'b0;
            end
            result_ready <= ($urandom_range(99) >= result_stall_pct);
        end
    end

    // Monitor: check results before predicting, a result never belongs to a same-edge request
    always @(posedge clk)
    begin
        item_taken <= item_valid && item_ready;
        cfg_taken <= cfg_valid && cfg_ready;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                apply_reg(check_state.cfg, cfg_index, cfg_data);
            if (result_valid && result_ready)
            begin
                observed = result;
                if (expected_results.size() == 0)
                begin
                    $error("result with no request outstanding: tx_byte %02h finished %0d",
                           observed.tx_byte, observed.finished);
                    error_count++;
                end
                else
                begin
                    predicted = expected_results.pop_front();
                    results_checked++;
                    if (observed.tx_byte !== predicted.tx_byte)
                    begin
                        $error("tx_byte: expected %02h, got %02h",
                               predicted.tx_byte, observed.tx_byte);
                        error_count++;
                    end
                    if (observed.select_active !== predicted.select_active)
                    begin
                        $error("select_active: expected %0d, got %0d",
                               predicted.select_active, observed.select_active);
                        error_count++;
                    end
                    if (observed.finished !== predicted.finished)
                    begin
                        $error("finished: expected %0d, got %0d",
                               predicted.finished, observed.finished);
                        error_count++;
                    end
                    if (observed.verdict !== predicted.verdict)
                    begin
                        $error("verdict: expected %0d, got %0d",
                               predicted.verdict, observed.verdict);
                        error_count++;
                    end
                    if (observed.card_kind !== predicted.card_kind)
                    begin
                        $error("card_kind: expected %0d, got %0d",
                               predicted.card_kind, observed.card_kind);
                        error_count++;
                    end
                end
            end
            if (item_valid && item_ready)
            begin
                seq_step(check_state, item, predicted);
                expected_results.push_back(predicted);
                if (predicted.finished && !last_finished)
                    verdict_seen[predicted.verdict]++;
                last_finished = predicted.finished;
            end
        end
    end

    initial
    begin
        check_state = reset_state();
        plan_state = reset_state();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset values: bytes while not running, ignored rx on start, restart mid-wake-up
        probe = PROBE_HC;
        push_item(KIND_BYTE, 8'h00);
        push_item(KIND_BYTE, 8'hFF);
        push_item(KIND_START, 8'hA5);
        push_item(KIND_BYTE, 8'h00);
        push_item(KIND_BYTE, 8'hFF);
        push_item(KIND_BYTE, 8'h55);
        push_item(KIND_BYTE, 8'hAA);
        push_item(KIND_START, 8'h00);
        push_item(KIND_BYTE, 8'hFF);
        push_item(KIND_BYTE, 8'h7F);
        wait_drained();

        // Short counts: two CMD0 tries and a single ACMD41 try
        run_phase(16'd1, 16'd2, 16'd1, 16'd1, 16'd4096, 0, 0, 150, 1'b1);
        run_phase(16'($urandom_range(6, 1)), 16'($urandom_range(4, 1)),
                  16'($urandom_range(6, 1)), 16'($urandom_range(15, 1)),
                  16'($urandom_range(4096, 1)), 78, 0, 200, 1'b1);
        run_phase(16'($urandom_range(6, 1)), 16'($urandom_range(4, 1)),
                  16'($urandom_range(6, 1)), 16'($urandom_range(15, 1)),
                  16'($urandom_range(4096, 1)), 0, 78, 200, 1'b1);
        run_phase(16'($urandom_range(6, 1)), 16'($urandom_range(4, 1)),
                  16'($urandom_range(6, 1)), 16'($urandom_range(15, 1)),
                  16'($urandom_range(4096, 1)), 22, 22, 200, 1'b1);
        // zero counts behave as one
        run_phase(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 0, 0, 100, 1'b1);
        // largest counts; an absent card would take thousands of requests here
        run_phase(16'd255, 16'd255, 16'd65535, 16'd15, 16'd4096, 22, 22, 400, 1'b0);

        $display("%0d results checked; checks ended unlocked %0d, locked %0d, no card %0d",
                 results_checked, verdict_seen[0], verdict_seen[1], verdict_seen[2]);
        $display("covered start/restart, all card paths, retry limits and six register sets");
        if (error_count == 0)
            $display("sd_spi_init_lock_check_test: clean");
        else
            $display("sd_spi_init_lock_check_test: errors");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("sd_spi_init_lock_check_test: errors");
        $finish;
    end

endmodule
